// File: rtl/eight_bit_accumulator_cpu_defines.svh
// ----------------------------------------------------------------------------
// eight_bit_accumulator_cpu_defines
// assertion macros shared by the checker of the accumulator cpu
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_ACCUMULATOR_CPU_DEFINES_SVH
`define EIGHT_BIT_ACCUMULATOR_CPU_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define EAC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("eac check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define EAC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("eac check failed");

`endif

// File: rtl/eac_pkg.sv
// ----------------------------------------------------------------------------
// eac_pkg
// types, codes and constants of the eight bit accumulator cpu
// ----------------------------------------------------------------------------
package eac_pkg;

	localparam int MEM_DEPTH = 16;

	// host command codes
	typedef enum logic [1:0] {
		KIND_STEP  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// instruction opcodes, the rest are illegal
	typedef enum logic [3:0] {
		OP_NOP = 4'd0,
		OP_LDA = 4'd1,
		OP_ADD = 4'd2,
		OP_SUB = 4'd3,
		OP_STA = 4'd4,
		OP_LDI = 4'd5,
		OP_JMP = 4'd6,
		OP_JC  = 4'd7,
		OP_JZ  = 4'd8,
		OP_OUT = 4'd14,
		OP_HLT = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_HALT    = 2'd1,
		ST_ILLEGAL = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] mem_address;
		logic [7:0] write_data;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] read_data;
		logic [7:0] out_value;
		logic [3:0] program_counter;
		logic [7:0] accumulator;
		logic       carry_flag;
		logic       zero_flag;
	} rsp_t;

	typedef struct packed {
		logic [3:0] pc;
		logic [7:0] acc;
		logic [7:0] operand;
		logic [7:0] out;
		logic [7:0] instr;
		logic       carry;
		logic       zero;
	} cpu_state_t;

	typedef struct packed {
		logic       en;
		logic [3:0] addr;
		logic [7:0] data;
	} mem_wr_t;

endpackage

// File: rtl/eac_regfile.sv
// ----------------------------------------------------------------------------
// eac_regfile
// unified program and data memory, one write port, all entries visible
// ----------------------------------------------------------------------------
module eac_regfile #(
	parameter int MEM_DEPTH = eac_pkg::MEM_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  eac_pkg::mem_wr_t            wr,
	output logic [MEM_DEPTH-1:0][7:0]   mem
);
	import eac_pkg::*;

	localparam int AW = $clog2(MEM_DEPTH);

	logic [MEM_DEPTH-1:0][7:0] mem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_q <= '0;
		end else if (wr.en) begin
			mem_q[wr.addr[AW-1:0]] <= wr.data;
		end
	end

	assign mem = mem_q;

endmodule

// File: rtl/eac_exec.sv
// ----------------------------------------------------------------------------
// eac_exec
// fetch, decode and execute of one host command in a single pass
// ----------------------------------------------------------------------------
module eac_exec #(
	parameter int MEM_DEPTH = eac_pkg::MEM_DEPTH
) (
	input  eac_pkg::cmd_t                cmd,
	input  eac_pkg::cpu_state_t          cur,
	input  logic [MEM_DEPTH-1:0][7:0]    mem,
	output eac_pkg::cpu_state_t          nxt,
	output eac_pkg::mem_wr_t             wr,
	output eac_pkg::rsp_t                rsp
);
	import eac_pkg::*;

	localparam int AW = $clog2(MEM_DEPTH);

	logic [7:0] instr;
	logic [3:0] arg;
	logic [7:0] mem_arg;
	logic [8:0] sum;
	logic [8:0] diff;
	logic [1:0] status;
	logic [7:0] rd;

	assign instr   = mem[cur.pc[AW-1:0]];
	assign arg     = instr[3:0];
	assign mem_arg = mem[arg[AW-1:0]];
	assign sum     = {1'b0, cur.acc} + {1'b0, mem_arg};
	// top bit is the borrow
	assign diff    = {1'b0, cur.acc} - {1'b0, mem_arg};

	always_comb begin
		nxt     = cur;
		wr      = '0;
		status  = ST_OK;
		rd      = '0;
		unique case (kind_t'(cmd.opcode))
			KIND_STEP: begin
				nxt.instr = instr;
				nxt.pc    = cur.pc + 4'd1;
				unique case (op_t'(instr[7:4]))
					OP_NOP: begin
					end
					OP_LDA: begin
						nxt.acc = mem_arg;
					end
					OP_ADD: begin
						nxt.operand = mem_arg;
						nxt.acc     = sum[7:0];
						nxt.carry   = sum[8];
						nxt.zero    = (sum[7:0] == 8'd0);
					end
					OP_SUB: begin
						nxt.operand = mem_arg;
						nxt.acc     = diff[7:0];
						nxt.carry   = diff[8];
						nxt.zero    = (diff[7:0] == 8'd0);
					end
					OP_STA: begin
						wr.en   = 1'b1;
						wr.addr = arg;
						wr.data = cur.acc;
					end
					OP_LDI: begin
						nxt.acc = {4'd0, arg};
					end
					OP_JMP: begin
						nxt.pc = arg;
					end
					OP_JC: begin
						if (cur.carry) begin
							nxt.pc    = arg;
							nxt.carry = 1'b0;
						end
					end
					OP_JZ: begin
						if (cur.zero) begin
							nxt.pc   = arg;
							nxt.zero = 1'b0;
						end
					end
					OP_OUT: begin
						nxt.out = cur.acc;
					end
					OP_HLT: begin
						status = ST_HALT;
					end
					default: begin
						status = ST_ILLEGAL;
					end
				endcase
			end
			KIND_WRITE: begin
				wr.en   = 1'b1;
				wr.addr = cmd.mem_address;
				wr.data = cmd.write_data;
			end
			KIND_READ: begin
				rd = mem[cmd.mem_address[AW-1:0]];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rsp.status          = status;
		rsp.read_data       = rd;
		rsp.out_value       = nxt.out;
		rsp.program_counter = nxt.pc;
		rsp.accumulator     = nxt.acc;
		rsp.carry_flag      = nxt.carry;
		rsp.zero_flag       = nxt.zero;
	end

endmodule

// File: rtl/eight_bit_accumulator_cpu.sv
// ----------------------------------------------------------------------------
// eight_bit_accumulator_cpu
// accumulator cpu with 16 bytes of unified memory, driven by host commands
// ----------------------------------------------------------------------------
// usage
//  cmd channel: one beat is a host command (step one instruction, write a
//   memory byte or read a memory byte), taken when cmd_valid and !cmd_stall
//  rsp channel: one beat per command, in order, with status, read byte and
//   the cpu registers after the command
//  path: a taken command waits in the input register and moves into the
//   response register once that is free; these are the two stages
//  throughput: one command per cycle unless a response is held; the whole
//   fetch, decode and execute sits between the input and response registers,
//   reading the 16 byte memory as flip-flops with one write port
//  stall: while rsp_stall holds a response, the input register keeps its
//   command and cmd_stall rises only when that register is also full
//  reset: arst_n clears memory, pc, accumulator, flags and both stages;
//   the block takes a command in the first cycle after reset
// ----------------------------------------------------------------------------
module eight_bit_accumulator_cpu #(
	parameter int MEM_DEPTH = eac_pkg::MEM_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  eac_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output eac_pkg::rsp_t  rsp
);
	import eac_pkg::*;

	logic                      cmd_valid_s1;
	cmd_t                      cmd_s1;
	cpu_state_t                state_q;
	cpu_state_t                state_nxt;
	mem_wr_t                   wr_nxt;
	mem_wr_t                   wr;
	rsp_t                      rsp_nxt;
	logic                      rsp_valid_q;
	rsp_t                      rsp_q;
	logic [MEM_DEPTH-1:0][7:0] mem;
	logic                      rsp_free;
	logic                      adv;
	logic                      cmd_fire;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign adv       = cmd_valid_s1 && rsp_free;
	assign cmd_stall = cmd_valid_s1 && !rsp_free;
	assign cmd_fire  = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else begin
			cmd_valid_s1 <= cmd_fire || (cmd_valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			cmd_s1 <= cmd;
		end
	end

	eac_regfile #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.mem    (mem)
	);

	eac_exec #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_exec (
		.cmd (cmd_s1),
		.cur (state_q),
		.mem (mem),
		.nxt (state_nxt),
		.wr  (wr_nxt),
		.rsp (rsp_nxt)
	);

	// memory only changes when the command really retires
	always_comb begin
		wr    = wr_nxt;
		wr.en = wr_nxt.en && adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/eac_checker.sv
// ----------------------------------------------------------------------------
// eac_checker
// port level checks of the accumulator cpu, bound to the top level
// ----------------------------------------------------------------------------
`include "eight_bit_accumulator_cpu_defines.svh"

module eac_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input eac_pkg::cmd_t  cmd,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input eac_pkg::rsp_t  rsp
);
	import eac_pkg::*;

	// a held response beat stays put
	`EAC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// a stalled command beat stays put
	`EAC_ASSERT_NEXT(a_cmd_hold, cmd_valid && cmd_stall, cmd_valid && $stable(cmd))

	// with the response register empty the input side never stalls
	`EAC_ASSERT_NOW(a_no_stall_when_empty, !rsp_valid, !cmd_stall)

	// only the defined status codes appear
	`EAC_ASSERT_NOW(a_status_code, rsp_valid, rsp.status <= ST_ILLEGAL)

	// a nonzero read byte only comes from a read, which always reports ok
	`EAC_ASSERT_NOW(a_read_status, rsp_valid && (rsp.read_data != 8'd0), rsp.status == ST_OK)

endmodule

bind eight_bit_accumulator_cpu eac_checker u_eac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the eight bit accumulator cpu
// ----------------------------------------------------------------------------
// commands go in on the cmd channel from one sender task, responses are
// compared field by field against a cycle-free software copy of the cpu
// kept in this module. a directed program runs every instruction first,
// then random command streams run under several idling mixes, including
// a long response hold-off that fills the block and stalls its input
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import eac_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam logic [3:0] OP_UNUSED = 4'd9;
	localparam op_t LEGAL_OPS [11] = '{OP_NOP, OP_LDA, OP_ADD, OP_SUB, OP_STA, OP_LDI,
		OP_JMP, OP_JC, OP_JZ, OP_OUT, OP_HLT};

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// software copy of the cpu
	logic [7:0] cpu_mem [MEM_DEPTH];
	logic [3:0] cpu_pc;
	logic [7:0] cpu_acc;
	logic [7:0] cpu_opnd;
	logic [7:0] cpu_out;
	logic [7:0] cpu_ir;
	logic       cpu_carry;
	logic       cpu_zero;

	rsp_t pending_rsp [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int rsp_hold_request = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int rsp_checked = 0;
	int cmds_sent = 0;
	int steps_run = 0;
	int halts_seen = 0;
	int illegals_seen = 0;
	int cmd_stall_cycles = 0;

	eight_bit_accumulator_cpu u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// applies one command to the software cpu and returns its response
	function automatic rsp_t exec_cmd(cmd_t c);
		rsp_t r;
		logic [3:0] op;
		logic [3:0] arg;
		logic [8:0] sum;
		r = '0;
		r.status = ST_OK;
		case (kind_t'(c.opcode))
			KIND_STEP: begin
				cpu_ir = cpu_mem[cpu_pc];
				cpu_pc = cpu_pc + 4'd1;
				op = cpu_ir[7:4];
				arg = cpu_ir[3:0];
				case (op)
					OP_NOP: ;
					OP_LDA: cpu_acc = cpu_mem[arg];
					OP_ADD: begin
						cpu_opnd = cpu_mem[arg];
						sum = {1'b0, cpu_acc} + {1'b0, cpu_opnd};
						cpu_acc = sum[7:0];
						cpu_carry = sum[8];
						cpu_zero = (sum[7:0] == 8'd0);
					end
					OP_SUB: begin
						// bit 8 of the 9-bit difference is the borrow
						cpu_opnd = cpu_mem[arg];
						sum = {1'b0, cpu_acc} - {1'b0, cpu_opnd};
						cpu_acc = sum[7:0];
						cpu_carry = sum[8];
						cpu_zero = (sum[7:0] == 8'd0);
					end
					OP_STA: cpu_mem[arg] = cpu_acc;
					OP_LDI: cpu_acc = {4'd0, arg};
					OP_JMP: cpu_pc = arg;
					OP_JC: begin
						if (cpu_carry) begin
							cpu_pc = arg;
							cpu_carry = 1'b0;
						end
					end
					OP_JZ: begin
						if (cpu_zero) begin
							cpu_pc = arg;
							cpu_zero = 1'b0;
						end
					end
					OP_OUT: cpu_out = cpu_acc;
					OP_HLT: r.status = ST_HALT;
					default: r.status = ST_ILLEGAL;
				endcase
			end
			KIND_WRITE: cpu_mem[c.mem_address] = c.write_data;
			KIND_READ: r.read_data = cpu_mem[c.mem_address];
			default: ;
		endcase
		r.out_value = cpu_out;
		r.program_counter = cpu_pc;
		r.accumulator = cpu_acc;
		r.carry_flag = cpu_carry;
		r.zero_flag = cpu_zero;
		return r;
	endfunction

	function automatic cmd_t mk_cmd(kind_t k, logic [3:0] a, logic [7:0] d);
		cmd_t c;
		c.opcode = k;
		c.mem_address = a;
		c.write_data = d;
		return c;
	endfunction

	// mostly steps and program bytes with a legal opcode, some raw noise
	function automatic cmd_t random_cmd();
		cmd_t c;
		int pick;
		pick = $urandom_range(99);
		c.mem_address = 4'($urandom_range(15));
		c.write_data = 8'($urandom_range(255));
		if (pick < 50) begin
			c.opcode = KIND_STEP;
		end else if (pick < 80) begin
			c.opcode = KIND_WRITE;
			if ($urandom_range(99) < 65)
				c.write_data[7:4] = LEGAL_OPS[$urandom_range(10)];
		end else if (pick < 92) begin
			c.opcode = KIND_READ;
		end else begin
			c.opcode = KIND_NONE;
		end
		return c;
	endfunction

	// one beat on the cmd channel; valid stays high after acceptance
	task automatic send_cmd(cmd_t c);
		rsp_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid = 1'b0;
			@(negedge clk);
		end
		cmd = c;
		cmd_valid = 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		r = exec_cmd(c);
		pending_rsp.push_back(r);
		cmds_sent++;
		if (c.opcode == KIND_STEP)
			steps_run++;
		if (r.status == ST_HALT)
			halts_seen++;
		if (r.status == ST_ILLEGAL)
			illegals_seen++;
	endtask

	task automatic wait_results();
		@(negedge clk);
		cmd_valid = 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_reset_state();
		send_cmd(mk_cmd(KIND_READ, 4'd0, 8'h00));
		send_cmd(mk_cmd(KIND_READ, 4'd15, 8'hFF));
		// unused command code must leave everything alone
		send_cmd(mk_cmd(KIND_NONE, 4'd15, 8'hFF));
	endtask

	// program touching every instruction, both outcomes of each branch,
	// carry and borrow, zero, an illegal opcode, halt and the pc wrap
	task automatic test_program();
		logic [7:0] prog [15];
		prog[0]  = {OP_LDI, 4'd1};
		prog[1]  = {OP_ADD, 4'd14};
		prog[2]  = {OP_JC, 4'd4};
		prog[3]  = 8'h00;
		prog[4]  = {OP_JZ, 4'd5};
		prog[5]  = {OP_JC, 4'd0};
		prog[6]  = {OP_SUB, 4'd14};
		prog[7]  = {OP_STA, 4'd15};
		prog[8]  = {OP_OUT, 4'd0};
		prog[9]  = {OP_UNUSED, 4'hA};
		prog[10] = {OP_HLT, 4'd0};
		prog[11] = {OP_LDA, 4'd15};
		prog[12] = {OP_JZ, 4'd0};
		prog[13] = {OP_JMP, 4'd15};
		prog[14] = 8'hFF;
		for (int i = 0; i < 15; i++)
			if (i != 3)
				send_cmd(mk_cmd(KIND_WRITE, 4'(i), prog[i]));
		// 14 steps: the last fetches the stored byte at 15 and wraps to 0
		repeat (14)
			send_cmd(mk_cmd(KIND_STEP, 4'd0, 8'd0));
		send_cmd(mk_cmd(KIND_READ, 4'd15, 8'd0));
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		rsp_hold_request = HOLD_OFF_CYCLES;
		repeat (24)
			send_cmd(random_cmd());
		wait_results();
	endtask

	task automatic run_random(int n, int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		repeat (n)
			send_cmd(random_cmd());
	endtask

	// receiver: long hold-off on request, otherwise random stall
	always @(negedge clk) begin
		if (rsp_hold_request != 0) begin
			hold_left = rsp_hold_request;
			rsp_hold_request = 0;
		end
		if (hold_left != 0) begin
			rsp_stall = 1'b1;
			hold_left--;
		end else begin
			rsp_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want != got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("response beat with nothing outstanding");
				mismatches++;
			end else begin
				want = pending_rsp.pop_front();
				check_field("status", 8'(want.status), 8'(rsp.status));
				check_field("read_data", want.read_data, rsp.read_data);
				check_field("out_value", want.out_value, rsp.out_value);
				check_field("program_counter", 8'(want.program_counter),
					8'(rsp.program_counter));
				check_field("accumulator", want.accumulator, rsp.accumulator);
				check_field("carry_flag", 8'(want.carry_flag), 8'(rsp.carry_flag));
				check_field("zero_flag", 8'(want.zero_flag), 8'(rsp.zero_flag));
				rsp_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && cmd_valid && cmd_stall)
			cmd_stall_cycles++;
		if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
			$display("eight_bit_accumulator_cpu: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cpu_mem = '{default: 8'd0};
		cpu_pc = '0;
		cpu_acc = '0;
		cpu_opnd = '0;
		cpu_out = '0;
		cpu_ir = '0;
		cpu_carry = 1'b0;
		cpu_zero = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 20;
		recv_stall_pct = 56;
		test_reset_state();
		test_program();
		wait_results();
		test_backpressure();
		run_random(700, 20, 56);
		wait_results();
		run_random(700, 56, 20);
		run_random(650, 0, 0);
		wait_results();
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);

		$display("%0d commands sent, %0d responses checked, %0d cycles of input stall",
			cmds_sent, rsp_checked, cmd_stall_cycles);
		$display("%0d instruction steps, %0d halts, %0d illegal opcodes",
			steps_run, halts_seen, illegals_seen);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("eight_bit_accumulator_cpu: match");
		end else begin
			$display("eight_bit_accumulator_cpu: mismatch");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/eac_pkg.sv
rtl/eac_regfile.sv
rtl/eac_exec.sv
rtl/eight_bit_accumulator_cpu.sv
rtl/eac_checker.sv
tb/sv/tb.sv
